FILE: rtl/core/lpa_pkg.sv
// shared types, constants and helpers for the looped phase accumulator
`timescale 1ns / 1ps

package lpa_pkg;

  localparam int PHASE_W  = 32;
  localparam int POS_W    = 31;
  localparam int DIV_BITS = 33;
  localparam int CNT_W    = $clog2(DIV_BITS);
  localparam int IDX_W    = 3;

  typedef logic [1:0] op_t;
  localparam op_t OP_TICK    = 2'd0;
  localparam op_t OP_RESTART = 2'd1;
  localparam op_t OP_LOAD    = 2'd2;

  typedef logic [IDX_W-1:0] reg_idx_t;
  localparam reg_idx_t REG_RATE  = 3'd0;
  localparam reg_idx_t REG_FRONT = 3'd1;
  localparam reg_idx_t REG_BACK  = 3'd2;
  localparam reg_idx_t REG_CYCLE = 3'd3;
  localparam reg_idx_t REG_WEND  = 3'd4;

  localparam logic signed [33:0] PHASE_MAX = 34'sd2147483647;
  localparam logic signed [33:0] PHASE_MIN = -34'sd2147483648;

  // effective loop window and mode, as seen by the sequencer
  typedef struct packed {
    logic [POS_W-1:0] front;
    logic [POS_W-1:0] back;
    logic [POS_W-1:0] len;
    logic             rate_pos;
    logic             cycle;
    logic             recheck;
  } win_t;

  typedef struct packed {
    logic                start;
    logic                neg;
    logic [DIV_BITS-1:0] mag;
    logic [POS_W-1:0]    divisor;
  } rem_req_t;

  typedef struct packed {
    logic                      done;
    logic signed [PHASE_W-1:0] remainder;
  } rem_rsp_t;

  function automatic logic in_window(input logic signed [33:0] p,
                                     input logic [POS_W-1:0] f,
                                     input logic [POS_W-1:0] b);
    logic lo_ok;
    logic hi_ok;
    lo_ok = p >= $signed({3'b000, f});
    hi_ok = p <= $signed({3'b000, b});
    return lo_ok && hi_ok;
  endfunction

  function automatic logic signed [PHASE_W-1:0] sat32(input logic signed [33:0] v);
    logic signed [PHASE_W-1:0] r;
    if (v > PHASE_MAX) begin
      r = PHASE_MAX[PHASE_W-1:0];
    end else if (v < PHASE_MIN) begin
      r = PHASE_MIN[PHASE_W-1:0];
    end else begin
      r = v[PHASE_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/lpa_cfg.sv
// configuration registers and registered effective loop window
`timescale 1ns / 1ps

module lpa_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               wr_en,
  input  lpa_pkg::reg_idx_t                  wr_index,
  input  logic [lpa_pkg::PHASE_W-1:0]        wr_data,
  output logic signed [lpa_pkg::PHASE_W-1:0] rate,
  output lpa_pkg::win_t                      win,
  output logic                               busy
);
  import lpa_pkg::*;

  logic signed [PHASE_W-1:0] rate_step;
  logic signed [PHASE_W-1:0] front_point;
  logic signed [PHASE_W-1:0] back_point;
  logic                      cycle_enable;
  logic [POS_W-1:0]          wave_end;

  logic [1:0]       settle;
  logic             touched;
  logic [POS_W-1:0] eff_front;
  logic [POS_W-1:0] eff_back;
  logic [POS_W-1:0] len;
  logic             rate_pos;
  logic [POS_W-1:0] eff_front_next;
  logic [POS_W-1:0] eff_back_next;
  logic [POS_W-1:0] len_next;

  always_comb begin
    eff_front_next = front_point[PHASE_W-1] ? '0 : front_point[POS_W-1:0];
    if (back_point[PHASE_W-1]) begin
      eff_back_next = wave_end;
    end else if (back_point[POS_W-1:0] < wave_end) begin
      eff_back_next = back_point[POS_W-1:0];
    end else begin
      eff_back_next = wave_end;
    end
    // inverted window uses the magnitude of the length
    if (eff_back >= eff_front) begin
      len_next = eff_back - eff_front;
    end else begin
      len_next = eff_front - eff_back;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_step    <= 32'sd4096;
      front_point  <= '0;
      back_point   <= -32'sd1;
      cycle_enable <= 1'b0;
      wave_end     <= '0;
      settle       <= 2'd2;
      touched      <= 1'b0;
      eff_front    <= '0;
      eff_back     <= '0;
      len          <= '0;
      rate_pos     <= 1'b1;
    end else begin
      eff_front <= eff_front_next;
      eff_back  <= eff_back_next;
      len       <= len_next;
      rate_pos  <= !rate_step[PHASE_W-1] && (rate_step != '0);
      if (wr_en) begin
        settle <= 2'd2;
        case (wr_index)
          REG_RATE:  rate_step <= wr_data;
          REG_FRONT: begin
            front_point <= wr_data;
            touched     <= 1'b1;
          end
          REG_BACK: begin
            back_point <= wr_data;
            touched    <= 1'b1;
          end
          REG_CYCLE: cycle_enable <= wr_data[0];
          REG_WEND: begin
            wave_end <= wr_data[POS_W-1:0];
            touched  <= 1'b1;
          end
          default: ;
        endcase
      end else if (settle != 2'd0) begin
        settle <= settle - 2'd1;
        if (settle == 2'd1) begin
          touched <= 1'b0;
        end
      end
    end
  end

  assign rate         = rate_step;
  assign busy         = settle != 2'd0;
  assign win.front    = eff_front;
  assign win.back     = eff_back;
  assign win.len      = len;
  assign win.rate_pos = rate_pos;
  assign win.cycle    = cycle_enable;
  assign win.recheck  = (settle == 2'd1) && touched;

endmodule

FILE: rtl/core/lpa_rem.sv
// bit-serial truncated remainder unit, one dividend bit per cycle
`timescale 1ns / 1ps

module lpa_rem (
  input  logic               clk,
  input  logic               rst,
  input  lpa_pkg::rem_req_t  req,
  output lpa_pkg::rem_rsp_t  rsp
);
  import lpa_pkg::*;

  typedef enum logic [1:0] {R_IDLE, R_RUN, R_FIX} rstate_t;

  rstate_t             state;
  logic [CNT_W-1:0]    count;
  logic [DIV_BITS-1:0] mag;
  logic [POS_W-1:0]    divisor;
  logic                neg;
  logic [POS_W-1:0]    rem;
  logic [POS_W:0]      trial;
  logic [POS_W:0]      diff;
  logic [POS_W-1:0]    rem_next;

  always_comb begin
    trial = {rem, mag[DIV_BITS-1]};
    diff  = trial - {1'b0, divisor};
    if (trial >= {1'b0, divisor}) begin
      rem_next = diff[POS_W-1:0];
    end else begin
      rem_next = trial[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= R_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= (state == R_FIX);
      case (state)
        R_IDLE: begin
          if (req.start) begin
            mag     <= req.mag;
            divisor <= req.divisor;
            neg     <= req.neg;
            rem     <= '0;
            count   <= CNT_W'(DIV_BITS - 1);
            state   <= R_RUN;
          end
        end
        R_RUN: begin
          rem <= rem_next;
          mag <= {mag[DIV_BITS-2:0], 1'b0};
          if (count == '0) begin
            state <= R_FIX;
          end else begin
            count <= count - 1'b1;
          end
        end
        R_FIX: begin
          // remainder takes the sign of the dividend
          rsp.remainder <= neg ? -$signed({1'b0, rem}) : $signed({1'b0, rem});
          state         <= R_IDLE;
        end
        default: state <= R_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/looped_phase_accumulator_unit.sv
// looped phase accumulator: sequencer, phase state and output register
`timescale 1ns / 1ps
//
// Input channel (in_valid/in_stall) takes one item: an opcode and new_phase.
// Tick reports the current phase and flag, then advances by rate_step;
// restart jumps to the loop front; load sets new_phase. Output channel
// (out_valid/out_stall) returns one item per input item, in order.
// The result is registered the cycle after acceptance. Restart, load and the
// unused code leave the block idle, so they can follow one per cycle while
// the output is not stalled. A tick that does not wrap, or wraps onto an
// empty loop, passes through the window check before the block is idle
// again; a tick that wraps in cycle mode also runs the bit-serial remainder
// unit, which shifts the 33 dividend bits through one subtract-and-compare
// stage. Configuration writes (wr_en/wr_index/wr_data) are to be made only
// while the block is idle; the block itself does not enforce this. The
// window then settles while in_stall is high. Reset restores the register
// defaults, sets the phase to zero with its flag set, and holds in_stall
// high while the window settles. While out_stall is high the result holds
// and no new item is taken until it leaves.
//
module looped_phase_accumulator_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  lpa_pkg::op_t                       opcode,
  input  logic signed [lpa_pkg::PHASE_W-1:0] new_phase,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [lpa_pkg::PHASE_W-1:0] phase_out,
  output logic                               phase_valid,
  input  logic                               wr_en,
  input  lpa_pkg::reg_idx_t                  wr_index,
  input  logic [lpa_pkg::PHASE_W-1:0]        wr_data
);
  import lpa_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_CHECK, ST_DIV} state_t;

  state_t                    state;
  logic signed [PHASE_W-1:0] phase_acc;
  logic                      phase_ok;
  logic signed [PHASE_W:0]   next_sum;

  logic signed [PHASE_W-1:0] rate;
  win_t                      win;
  logic                      cfg_busy;
  rem_req_t                  rem_req;
  rem_rsp_t                  rem_rsp;

  logic                      accept;
  logic signed [33:0]        next34;
  logic signed [33:0]        f34;
  logic signed [33:0]        b34;
  logic signed [33:0]        opa;
  logic signed [33:0]        opb;
  logic signed [33:0]        diff_ab;
  logic signed [33:0]        diff_ba;
  logic                      good;
  logic                      wrap;
  logic signed [33:0]        rem34;
  logic signed [33:0]        wrapped;

  lpa_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .rate     (rate),
    .win      (win),
    .busy     (cfg_busy)
  );

  lpa_rem u_rem (
    .clk (clk),
    .rst (rst),
    .req (rem_req),
    .rsp (rem_rsp)
  );

  assign in_stall = !((state == ST_IDLE) && !cfg_busy && (!out_valid || !out_stall));
  assign accept   = in_valid && !in_stall;

  always_comb begin
    next34  = {next_sum[PHASE_W], next_sum};
    f34     = {3'b000, win.front};
    b34     = {3'b000, win.back};
    good    = in_window(next34, win.front, win.back);
    wrap    = win.cycle && !good;
    // forward rates measure from the front, others from the back
    opa     = win.rate_pos ? next34 : b34;
    opb     = win.rate_pos ? f34 : next34;
    diff_ab = opa - opb;
    diff_ba = opb - opa;
    rem_req.start   = (state == ST_CHECK) && wrap && (win.len != '0);
    rem_req.neg     = diff_ab[33];
    rem_req.mag     = diff_ab[33] ? diff_ba[DIV_BITS-1:0] : diff_ab[DIV_BITS-1:0];
    rem_req.divisor = win.len;
    rem34   = {{2{rem_rsp.remainder[PHASE_W-1]}}, rem_rsp.remainder};
    wrapped = win.rate_pos ? (f34 + rem34) : (b34 - rem34);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase_acc <= '0;
      phase_ok  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (win.recheck) begin
        phase_ok <= in_window({{2{phase_acc[PHASE_W-1]}}, phase_acc}, win.front, win.back);
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (opcode)
              OP_TICK: begin
                phase_out   <= phase_acc;
                phase_valid <= phase_ok;
                next_sum    <= {phase_acc[PHASE_W-1], phase_acc} + {rate[PHASE_W-1], rate};
                state       <= ST_CHECK;
              end
              OP_RESTART: begin
                phase_acc   <= {1'b0, win.front};
                phase_ok    <= 1'b1;
                phase_out   <= {1'b0, win.front};
                phase_valid <= 1'b1;
              end
              OP_LOAD: begin
                phase_acc   <= new_phase;
                phase_ok    <= in_window({{2{new_phase[PHASE_W-1]}}, new_phase},
                                         win.front, win.back);
                phase_out   <= new_phase;
                phase_valid <= in_window({{2{new_phase[PHASE_W-1]}}, new_phase},
                                         win.front, win.back);
              end
              default: begin
                phase_out   <= phase_acc;
                phase_valid <= phase_ok;
              end
            endcase
          end
        end
        ST_CHECK: begin
          if (!wrap) begin
            phase_acc <= sat32(next34);
            phase_ok  <= good;
            state     <= ST_IDLE;
          end else if (win.len == '0) begin
            // zero-length loop parks at the front
            phase_acc <= {1'b0, win.front};
            phase_ok  <= 1'b1;
            state     <= ST_IDLE;
          end else begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (rem_rsp.done) begin
            phase_acc <= sat32(wrapped);
            phase_ok  <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    rem_rsp.done |-> state == ST_DIV)
    else $error("remainder finished outside the wrap phase");

  a_wrap_sets_ok: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && rem_rsp.done) |=> phase_ok)
    else $error("wrapped step left phase flag clear");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted item produced no result");

  a_tick_checks: assert property (@(posedge clk) disable iff (rst)
    (accept && opcode == OP_TICK) |=> state == ST_CHECK)
    else $error("tick did not enter window check");

endmodule
